@@ rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker file of the queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a synchronous active-low reset.
`define KRQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under a synchronous active-low reset.
`define KRQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/krq_pkg.sv @@
// Package with the types and constants of the k-th removal queue.
`timescale 1ns / 1ps

package krq_pkg;

  // Number of slots; must be a power of two.
  localparam int CAPACITY   = 1024;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = IDX_W + 1;
  localparam int NODE_W     = IDX_W + 1;
  localparam int TREE_DEPTH = 2 * CAPACITY;
  localparam int VALUE_W    = 32;
  localparam int POS_W      = 11;
  localparam int CMP_W      = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_APPENDED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_NONE     = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [VALUE_W-1:0] item_value;
    logic [POS_W-1:0]   position;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] out_value;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WRITE,
    S_FETCH
  } state_t;

endpackage

@@ rtl/krq_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module krq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/kth_removal_queue.sv @@
// Top level of the k-th removal queue: control sequencer around two RAMs.
`timescale 1ns / 1ps

// The queue takes appends at the back and removes the k-th live element in
// arrival order. A request is taken when start is high and busy is low; its
// single result appears on out_rsp, flagged by out_strobe for exactly one
// cycle, and the receiver cannot hold it off. Values sit in a slot RAM
// in arrival order, and a second RAM holds a binary tree of live counts over
// the slots (node 1 is the root, the leaves are nodes CAPACITY and up). A
// request that needs no tree walk (append to a full queue, removal at rank
// zero or beyond the live count) is answered in the cycle after it is taken
// and busy stays low. An append or a valid removal walks the tree from the
// root to a leaf, each level being a read followed by a write of the count
// RAM, while busy stays high, and the result appears together with busy
// falling. Slots are never reused: once CAPACITY appends have been taken
// every further append reports full. The count RAM needs no clearing pass
// after reset: a node whose slot range starts at or beyond the number of
// slots ever filled has never been written and is taken as zero, so the
// block accepts requests straight out of reset.
module kth_removal_queue import krq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_strobe,
  output rsp_t out_rsp
);

  // Sequencer state.
  state_t            state_r, state_nxt;
  cmd_t              op_r, op_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  // Remaining slot bits of the append path, consumed from the top.
  logic [IDX_W-1:0]  path_r, path_nxt;
  // Count of the current node and remaining rank during a removal.
  logic [CNT_W-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0]  rank_r, rank_nxt;
  logic [CNT_W-1:0]  slots_used_r, slots_used_nxt;
  logic [CNT_W-1:0]  live_r, live_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  rsp_t              out_rsp_r, out_rsp_nxt;

  // Count tree RAM ports.
  logic              tree_we;
  logic [NODE_W-1:0] tree_waddr;
  logic [CNT_W-1:0]  tree_wdata;
  logic [NODE_W-1:0] tree_raddr;
  logic [CNT_W-1:0]  tree_rdata;

  // Slot value RAM ports.
  logic               val_we;
  logic [IDX_W-1:0]   val_waddr;
  logic [VALUE_W-1:0] val_wdata;
  logic [IDX_W-1:0]   val_raddr;
  logic [VALUE_W-1:0] val_rdata;

  logic              leaf;
  logic [CNT_W-1:0]  old_count;
  logic [NODE_W-1:0] left_child;
  logic [NODE_W-1:0] right_child;

  krq_ram #(
    .WIDTH (CNT_W),
    .DEPTH (TREE_DEPTH)
  ) u_tree_ram (
    .clk   (clk),
    .we    (tree_we),
    .waddr (tree_waddr),
    .wdata (tree_wdata),
    .raddr (tree_raddr),
    .rdata (tree_rdata)
  );

  krq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  // The leaves are the nodes with the top index bit set.
  assign leaf        = node_r[IDX_W];
  assign left_child  = {node_r[NODE_W-2:0], 1'b0};
  assign right_child = {node_r[NODE_W-2:0], 1'b1};

  // On an append, the node on the path is untouched exactly when the new slot
  // is the first slot of its range, that is when the slot bits still to be
  // consumed are all zero. Such a node reads as an empty count.
  assign old_count = (|path_r) ? tree_rdata : '0;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    node_nxt       = node_r;
    path_nxt       = path_r;
    cur_nxt        = cur_r;
    rank_nxt       = rank_r;
    slots_used_nxt = slots_used_r;
    live_nxt       = live_r;
    out_strobe_nxt = 1'b0;
    out_rsp_nxt    = out_rsp_r;

    tree_we    = 1'b0;
    tree_waddr = node_r;
    tree_wdata = '0;
    tree_raddr = node_r;
    val_we     = 1'b0;
    val_waddr  = slots_used_r[IDX_W-1:0];
    val_wdata  = in_req.item_value;
    val_raddr  = node_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_req.cmd == CMD_APPEND) begin
            if (slots_used_r == CNT_W'(CAPACITY)) begin
              out_strobe_nxt = 1'b1;
              out_rsp_nxt    = '{status: ST_FULL, out_value: '0};
            end else begin
              // The value goes straight into its slot; the tree walk follows.
              val_we    = 1'b1;
              op_nxt    = CMD_APPEND;
              node_nxt  = NODE_W'(1);
              path_nxt  = slots_used_r[IDX_W-1:0];
              state_nxt = S_READ;
            end
          end else begin
            if ((in_req.position == '0) ||
                (CMP_W'(in_req.position) > CMP_W'(live_r))) begin
              out_strobe_nxt = 1'b1;
              out_rsp_nxt    = '{status: ST_NONE, out_value: '0};
            end else begin
              // The root count always equals the live count.
              op_nxt    = CMD_REMOVE;
              node_nxt  = NODE_W'(1);
              cur_nxt   = live_r;
              rank_nxt  = CNT_W'(in_req.position);
              state_nxt = S_READ;
            end
          end
        end
      end

      S_READ: begin
        if (op_r == CMD_APPEND) begin
          tree_raddr = node_r;
          state_nxt  = S_WRITE;
        end else if (leaf) begin
          tree_we    = 1'b1;
          tree_wdata = cur_r - CNT_W'(1);
          val_raddr  = node_r[IDX_W-1:0];
          state_nxt  = S_FETCH;
        end else begin
          tree_raddr = left_child;
          state_nxt  = S_WRITE;
        end
      end

      S_WRITE: begin
        tree_we = 1'b1;
        if (op_r == CMD_APPEND) begin
          tree_wdata = old_count + CNT_W'(1);
          if (leaf) begin
            slots_used_nxt = slots_used_r + CNT_W'(1);
            live_nxt       = live_r + CNT_W'(1);
            out_strobe_nxt = 1'b1;
            out_rsp_nxt    = '{status: ST_APPENDED, out_value: '0};
            state_nxt      = S_IDLE;
          end else begin
            node_nxt  = {node_r[NODE_W-2:0], path_r[IDX_W-1]};
            path_nxt  = {path_r[IDX_W-2:0], 1'b0};
            state_nxt = S_READ;
          end
        end else begin
          // Every node on a removal path holds at least one live entry, so
          // the decrement cannot wrap. The right child's count follows from
          // the parent's count minus the left child's.
          tree_wdata = cur_r - CNT_W'(1);
          if (rank_r <= tree_rdata) begin
            node_nxt = left_child;
            cur_nxt  = tree_rdata;
          end else begin
            node_nxt = right_child;
            cur_nxt  = cur_r - tree_rdata;
            rank_nxt = rank_r - tree_rdata;
          end
          state_nxt = S_READ;
        end
      end

      S_FETCH: begin
        live_nxt       = live_r - CNT_W'(1);
        out_strobe_nxt = 1'b1;
        out_rsp_nxt    = '{status: ST_REMOVED, out_value: val_rdata};
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slots_used_r <= '0;
      live_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slots_used_r <= slots_used_nxt;
      live_r       <= live_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Walk registers and the result payload need no reset.
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    node_r    <= node_nxt;
    path_r    <= path_nxt;
    cur_r     <= cur_nxt;
    rank_r    <= rank_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

endmodule

@@ rtl/krq_checker.sv @@
// Port-level assertion checker for the k-th removal queue, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module krq_checker import krq_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input rsp_t out_rsp
);

  // A taken request is either answered in the next cycle or starts a walk.
  `KRQ_ASSERT_NXT(a_req_answered, clk, rst_n, start && !busy, out_strobe || busy, "request neither answered nor started")

  // A walk always ends with its result.
  `KRQ_ASSERT_IMP(a_walk_ends_with_result, clk, rst_n, $fell(busy), out_strobe, "walk ended without a result")

  // Every result stems from a request taken in the previous cycle or from a walk ending.
  `KRQ_ASSERT_IMP(a_no_stray_result, clk, rst_n, out_strobe, $past(start && !busy) || $fell(busy), "result without a request")

  // Only a removal carries a value.
  `KRQ_ASSERT_IMP(a_value_only_on_removal, clk, rst_n, out_strobe && (out_rsp.status != ST_REMOVED), out_rsp.out_value == '0, "value on a result that is not a removal")

endmodule

bind kth_removal_queue krq_checker u_krq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_rsp    (out_rsp)
);

@@ dv/krq_checker.sv @@
// Checker for the k-th removal queue: predicts each response and compares it.
`timescale 1ns / 1ps

module krq_tb_checker import krq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  req_t in_req,
  input  logic out_strobe,
  input  rsp_t out_rsp,
  output int   errors,
  output int   pending
);

  // Live values in arrival order; removing the k-th one is a delete at k-1.
  logic [VALUE_W-1:0] live_values[$];
  rsp_t               expected_rsp[$];
  int                 slots_filled;

  task automatic report(string what, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    $display("%0t: mismatch on %s: expected 0x%08h, got 0x%08h", $realtime, what, want, got);
    errors++;
  endtask

  // Works out the response to one request and updates the predicted contents.
  function automatic rsp_t predict_response(req_t r);
    rsp_t a;
    int   rank;
    rank        = int'(r.position);
    a.status    = ST_NONE;
    a.out_value = '0;
    if (r.cmd == CMD_APPEND) begin
      if (slots_filled >= CAPACITY) begin
        a.status = ST_FULL;
      end else begin
        live_values.insert(live_values.size(), r.item_value);
        slots_filled++;
        a.status = ST_APPENDED;
      end
    end else if (rank != 0 && rank <= live_values.size()) begin
      a.out_value = live_values[rank-1];
      live_values.delete(rank-1);
      a.status = ST_REMOVED;
    end
    return a;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      live_values.delete();
      expected_rsp.delete();
      slots_filled = 0;
      errors       = 0;
    end else begin
      // The response leaving now always belongs to an older request, so it is
      // checked before a request taken at this same edge is predicted.
      if (out_strobe) begin
        if (expected_rsp.size() == 0) begin
          report("unexpected response", '0, {30'd0, out_rsp.status});
        end else begin
          want = expected_rsp.pop_front();
          if (out_rsp.status !== want.status)
            report("status", {30'd0, want.status}, {30'd0, out_rsp.status});
          if (out_rsp.out_value !== want.out_value)
            report("out_value", want.out_value, out_rsp.out_value);
        end
      end
      if (start && !busy) begin
        want = predict_response(in_req);
        expected_rsp.insert(expected_rsp.size(), want);
      end
    end
    pending = expected_rsp.size();
  end

endmodule

@@ dv/tb_kth_removal_queue.sv @@
// Testbench top for the k-th removal queue: request stimulus and verdict.
`timescale 1ns / 1ps

module tb_kth_removal_queue;
  import krq_pkg::*;

  // A valid walk keeps the block busy for a read and a write per tree level.
  localparam int WALK_CYCLES = 2 * (IDX_W + 1);
  // Cycles without any request or response taken before the run is abandoned.
  // The longest idle gap and a full walk are both far shorter, so this is ample.
  localparam int QUIET_LIMIT = 1000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_req;
  logic out_strobe;
  rsp_t out_rsp;
  int   errors;
  int   pending;
  int   idle_cycles;

  // Bookkeeping of our own stimulus, used only to shape the ranks we ask for.
  int   slots_filled;
  int   live_total;
  int   sent;
  logic calm;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  kth_removal_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp)
  );

  krq_tb_checker u_tb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp),
    .errors     (errors),
    .pending    (pending)
  );

  // The watchdog restarts its count whenever a request or a response is taken,
  // so it only fires when the block has stopped making progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Presents one request, holds it until the block takes it, then idles for a
  // random gap. When no gap follows, start simply stays high for the next
  // request, so it is never lowered and raised within one time step.
  task automatic send(cmd_t c, logic [VALUE_W-1:0] v, logic [POS_W-1:0] k);
    req_t r;
    int   gap;
    int   roll;
    r.cmd        = c;
    r.item_value = v;
    r.position   = k;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) begin
      gap = 0;
    end else if (roll < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
    in_req <= r;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
    if (c == CMD_APPEND) begin
      if (slots_filled < CAPACITY) begin
        slots_filled++;
        live_total++;
      end
    end else if (k != 0 && int'(k) <= live_total) begin
      live_total--;
    end
    sent++;
    // Every so often switch between a stretch with idling and one without.
    if (sent % 64 == 0)
      calm = ($urandom_range(0, 3) == 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int               n;
    int               after_full;
    int               roll;
    logic             do_append;
    logic [VALUE_W-1:0] v;
    logic [POS_W-1:0]   k;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_req       = '0;
    slots_filled = 0;
    live_total   = 0;
    sent         = 0;
    calm         = 1'b0;
    n            = 0;
    after_full   = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Removals on an empty queue, rank zero, ranks just above
    // the live count and at the top of the field, removal of the newest and
    // oldest entries, extreme values, and ignored fields set to all ones.
    send(CMD_REMOVE, 32'h0000_0000, 11'd1);
    send(CMD_REMOVE, 32'h0000_0000, 11'd0);
    send(CMD_APPEND, 32'h0000_0000, 11'd0);
    send(CMD_APPEND, 32'hFFFF_FFFF, 11'd0);
    send(CMD_APPEND, 32'h5A5A_5A5A, 11'd0);
    send(CMD_REMOVE, 32'h0000_0000, 11'd0);
    send(CMD_REMOVE, 32'h0000_0000, 11'd4);
    send(CMD_REMOVE, 32'h0000_0000, 11'd3);
    send(CMD_REMOVE, 32'h0000_0000, 11'd1);
    send(CMD_APPEND, 32'hA5A5_A5A5, 11'd0);
    send(CMD_REMOVE, 32'h0000_0000, 11'h7FF);
    send(CMD_REMOVE, 32'h0000_0000, 11'd1024);
    send(CMD_REMOVE, 32'h0000_0000, 11'd2);
    send(CMD_REMOVE, 32'h0000_0000, 11'd1);
    send(CMD_REMOVE, 32'h0000_0000, 11'd1);
    send(CMD_APPEND, 32'h0000_0001, 11'h7FF);
    send(CMD_APPEND, 32'h8000_0000, 11'h555);
    send(CMD_REMOVE, 32'hFFFF_FFFF, 11'd2);
    send(CMD_REMOVE, 32'hFFFF_FFFF, 11'd1);

    // Random part. Appends dominate until every slot has been used, so the
    // queue grows deep and the full case is reached; after that the mix turns
    // towards removals, with full reports from the appends still sent.
    while (!(n >= 1150 && slots_filled == CAPACITY && after_full >= 60)) begin
      roll = $urandom_range(0, 99);
      if (slots_filled < CAPACITY) begin
        do_append = (roll < 85);
      end else begin
        do_append = (roll < 35);
      end
      if (do_append) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          v = '0;
        end else if (roll < 16) begin
          v = '1;
        end else begin
          v = $urandom;
        end
        k = POS_W'($urandom);
        send(CMD_APPEND, v, k);
      end else begin
        roll = $urandom_range(0, 99);
        if (live_total == 0) begin
          k = (roll < 50) ? POS_W'(roll % 2) : POS_W'($urandom);
        end else if (roll < 65) begin
          k = POS_W'($urandom_range(1, live_total));
        end else if (roll < 75) begin
          k = 11'd1;
        end else if (roll < 85) begin
          k = POS_W'(live_total);
        end else if (roll < 90) begin
          k = 11'd0;
        end else if (roll < 95) begin
          k = POS_W'(live_total + 1);
        end else begin
          k = POS_W'($urandom);
        end
        send(CMD_REMOVE, $urandom, k);
      end
      n++;
      if (slots_filled == CAPACITY)
        after_full++;
    end

    // Drain: wait for every predicted response, then allow a full walk's worth
    // of cycles so that any stray response would still be caught.
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (WALK_CYCLES + 10) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
